>>> rtl/plbt_pkg.sv
// ----------------------------------------------------------------------------
// plbt_pkg
// Shared types, register indexes and step tables for the parallel link byte
// transfer block.
// ----------------------------------------------------------------------------
package plbt_pkg;

    // Width of the poll counter by default.
    localparam int POLL_COUNT_BITS_DEF = 16;

    // Configuration register widths and reset values.
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [15:0] POLL_LIMIT_RST   = 16'd1000;
    localparam logic [7:0]  SETTLE_TICKS_RST = 8'd4;
    localparam logic [4:0]  RECV_RETRIES_RST = 5'd20;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RECV_RETRIES = 2'd2;

    // Input modes.
    localparam logic [1:0] MODE_SEND = 2'd1;
    localparam logic [1:0] MODE_RECV = 2'd2;

    // Partner status codes.
    localparam logic [1:0] STAT_ZERO = 2'd0;
    localparam logic [1:0] STAT_TWO  = 2'd2;
    localparam logic [1:0] STAT_IDLE = 2'd3;

    // Line patterns driven by the fixed steps.
    localparam logic [3:0] LINES_SEND_REQ  = 4'h9;
    localparam logic [3:0] LINES_RECV_REQ1 = 4'hB;
    localparam logic [3:0] LINES_RECV_REQ2 = 4'hF;
    localparam logic [3:0] LINES_BIT_REQ   = 4'hC;
    localparam logic [3:0] LINES_ZERO_ACK  = 4'hD;
    localparam logic [3:0] LINES_ONE_ACKA  = 4'hE;
    localparam logic [3:0] LINES_ONE_ACKB  = 4'hA;
    localparam logic [3:0] LINES_STROBE    = 4'h8;

    // Transfer steps, one-hot.
    typedef enum logic [12:0] {
        STEP_IDLE   = 13'b0000000000001,
        STEP_SREQ   = 13'b0000000000010,
        STEP_SG0    = 13'b0000000000100,
        STEP_SG1    = 13'b0000000001000,
        STEP_SG2    = 13'b0000000010000,
        STEP_RREQ1  = 13'b0000000100000,
        STEP_RREQ2  = 13'b0000001000000,
        STEP_RBIT   = 13'b0000010000000,
        STEP_RZERO  = 13'b0000100000000,
        STEP_RONEA  = 13'b0001000000000,
        STEP_RONEB  = 13'b0010000000000,
        STEP_RONEC  = 13'b0100000000000,
        STEP_RFINAL = 13'b1000000000000
    } t_step;

    // Full line pattern that a step drives.
    function automatic logic [3:0] step_value(t_step step, logic [7:0] tx_hold);
        logic [3:0] val;
        begin
            case (step)
                STEP_SREQ:   val = LINES_SEND_REQ;
                STEP_SG0:    val = {1'b0, tx_hold[2:0]};
                STEP_SG1:    val = {1'b1, tx_hold[5:3]};
                STEP_SG2:    val = {2'b00, tx_hold[7:6]};
                STEP_RREQ1:  val = LINES_RECV_REQ1;
                STEP_RREQ2:  val = LINES_RECV_REQ2;
                STEP_RBIT:   val = LINES_BIT_REQ;
                STEP_RZERO:  val = LINES_ZERO_ACK;
                STEP_RONEA:  val = LINES_ONE_ACKA;
                STEP_RONEB:  val = LINES_ONE_ACKB;
                STEP_RONEC:  val = LINES_STROBE;
                STEP_RFINAL: val = LINES_BIT_REQ;
                default:     val = 4'h0;
            endcase
            return val;
        end
    endfunction

    // Status that ends the wait of a step.
    function automatic logic [1:0] step_expect(t_step step);
        logic [1:0] st;
        begin
            case (step)
                STEP_SREQ, STEP_SG1, STEP_RREQ1, STEP_RONEA: st = STAT_TWO;
                STEP_RONEB:                                  st = STAT_ZERO;
                default:                                     st = STAT_IDLE;
            endcase
            return st;
        end
    endfunction

endpackage

>>> rtl/parallel_link_byte_transfer.sv
// ----------------------------------------------------------------------------
// parallel_link_byte_transfer
// Host side of a four-line handshaked link: sends and receives single bytes,
// one status sample per input beat.
// ----------------------------------------------------------------------------
// The result of an input beat is registered and is valid in the cycle after
// it is accepted. Throughput: one beat per cycle unless a waiting result is
// stalled; the transfer sequencer is updated in a single pass per beat, and
// the result register frees as it is read.
// Reset (synchronous, active low) returns the sequencer to idle, clears all
// counters and lines, and restores the register defaults.
module parallel_link_byte_transfer
    import plbt_pkg::*;
#(
    parameter int POLL_COUNT_BITS = POLL_COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port.
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input channel.
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_mode,
    input  logic [7:0]            i_tx_byte,
    input  logic [1:0]            i_line_in,
    // Result channel.
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [3:0]            o_line_out,
    output logic                  o_busy_res,
    output logic                  o_done_res,
    output logic [7:0]            o_rx_byte,
    output logic                  o_error
);

    localparam int LIM_W = (POLL_COUNT_BITS > 16) ? POLL_COUNT_BITS : 16;
    localparam logic [POLL_COUNT_BITS-1:0] CNT_MAX = {POLL_COUNT_BITS{1'b1}};

    // Configuration registers.
    logic [15:0] r_poll_limit;
    logic [7:0]  r_settle_ticks;
    logic [4:0]  r_recv_retries;

    // Sequencer state.
    t_step                      r_step, n_step;
    logic                       r_wait, n_wait;
    logic [POLL_COUNT_BITS-1:0] r_poll_cnt, n_poll_cnt;
    logic [7:0]                 r_settle_cnt, n_settle_cnt;
    logic [4:0]                 r_retry, n_retry;
    logic [7:0]                 r_shift, n_shift;
    logic [3:0]                 r_bit_cnt, n_bit_cnt;
    logic [7:0]                 r_tx_hold, n_tx_hold;
    logic [3:0]                 r_lines, n_lines;

    // Result register.
    logic       r_out_valid;
    logic [3:0] r_out_lines;
    logic       r_out_busy;
    logic       r_out_done;
    logic [7:0] r_out_rx;
    logic       r_out_err;

    logic       in_accept;
    logic       fin, fin_err, fin_rx;
    logic [LIM_W-1:0] lim;

    // The input is held off only while a result waits and is stalled.
    assign o_stall   = r_out_valid & i_stall;
    assign in_accept = i_valid & ~o_stall;

    // Effective poll limit: zero acts as one, clamped to the counter range.
    always_comb begin
        lim = (r_poll_limit == 16'd0) ? LIM_W'(1) : LIM_W'(r_poll_limit);
        if (lim > LIM_W'(CNT_MAX)) begin
            lim = LIM_W'(CNT_MAX);
        end
    end

    // Next state of the sequencer for one beat.
    always_comb begin
        logic       do_enter;
        logic       do_strobe;
        t_step      ent_step;
        t_step      str_step;
        logic       hit;
        logic [3:0] val;

        do_enter  = 1'b0;
        do_strobe = 1'b0;
        ent_step  = STEP_IDLE;
        str_step  = STEP_IDLE;
        hit       = 1'b0;
        val       = 4'h0;

        n_step       = r_step;
        n_wait       = r_wait;
        n_poll_cnt   = r_poll_cnt;
        n_settle_cnt = r_settle_cnt;
        n_retry      = r_retry;
        n_shift      = r_shift;
        n_bit_cnt    = r_bit_cnt;
        n_tx_hold    = r_tx_hold;
        n_lines      = r_lines;
        fin          = 1'b0;
        fin_err      = 1'b0;
        fin_rx       = 1'b0;

        if (r_step == STEP_IDLE) begin
            // Start a transfer.
            if (i_mode == MODE_SEND) begin
                n_tx_hold = i_tx_byte;
                do_enter  = 1'b1;
                ent_step  = STEP_SREQ;
            end else if (i_mode == MODE_RECV) begin
                n_retry   = 5'd0;
                n_bit_cnt = 4'd0;
                n_shift   = 8'd0;
                do_enter  = 1'b1;
                ent_step  = STEP_RREQ1;
            end
        end else if (!r_wait) begin
            // Settle: hold the low lines, then raise the full value.
            if (r_settle_cnt != 8'd0) begin
                n_settle_cnt = r_settle_cnt - 8'd1;
            end
            if (n_settle_cnt == 8'd0) begin
                do_strobe = 1'b1;
                str_step  = r_step;
            end
        end else begin
            // Poll the partner status.
            hit = (r_step == STEP_RBIT) ? (i_line_in != STAT_IDLE)
                                        : (i_line_in == step_expect(r_step));
            if (hit) begin
                case (r_step)
                    STEP_SREQ: begin
                        do_enter = 1'b1;
                        ent_step = STEP_SG0;
                    end
                    STEP_SG0: begin
                        do_enter = 1'b1;
                        ent_step = STEP_SG1;
                    end
                    STEP_SG1: begin
                        do_enter = 1'b1;
                        ent_step = STEP_SG2;
                    end
                    STEP_SG2: begin
                        fin = 1'b1;
                    end
                    STEP_RREQ1: begin
                        do_enter = 1'b1;
                        ent_step = STEP_RREQ2;
                    end
                    STEP_RREQ2: begin
                        do_enter = 1'b1;
                        ent_step = STEP_RBIT;
                    end
                    STEP_RBIT: begin
                        n_shift   = {i_line_in != STAT_TWO, r_shift[7:1]};
                        n_bit_cnt = r_bit_cnt + 4'd1;
                        do_enter  = 1'b1;
                        ent_step  = (i_line_in != STAT_TWO) ? STEP_RONEA : STEP_RZERO;
                    end
                    STEP_RONEA: begin
                        do_enter = 1'b1;
                        ent_step = STEP_RONEB;
                    end
                    STEP_RONEB: begin
                        do_enter = 1'b1;
                        ent_step = STEP_RONEC;
                    end
                    STEP_RZERO, STEP_RONEC: begin
                        do_enter = 1'b1;
                        ent_step = (r_bit_cnt >= 4'd8) ? STEP_RFINAL : STEP_RBIT;
                    end
                    default: begin
                        n_step = STEP_IDLE;
                        n_wait = 1'b0;
                    end
                endcase
            end else begin
                if (r_poll_cnt != CNT_MAX) begin
                    n_poll_cnt = r_poll_cnt + POLL_COUNT_BITS'(1);
                end
                if (LIM_W'(n_poll_cnt) >= lim) begin
                    // A request that times out is retried until the
                    // attempts run out; any other timeout ends the transfer.
                    if (r_step inside {STEP_RREQ1, STEP_RREQ2}) begin
                        n_retry = r_retry + 5'd1;
                        if (n_retry >= r_recv_retries || n_retry == 5'd0) begin
                            fin     = 1'b1;
                            fin_err = 1'b1;
                        end else begin
                            do_enter = 1'b1;
                            ent_step = STEP_RREQ1;
                        end
                    end else begin
                        fin     = 1'b1;
                        fin_err = 1'b1;
                    end
                end
            end
        end

        // Enter a step: the low lines change first, the strobe keeps its value.
        if (do_enter) begin
            val          = step_value(ent_step, n_tx_hold);
            n_lines      = {r_lines[3], val[2:0]};
            n_settle_cnt = r_settle_ticks;
            if (r_settle_ticks == 8'd0) begin
                do_strobe = 1'b1;
                str_step  = ent_step;
            end else begin
                n_step = ent_step;
                n_wait = 1'b0;
            end
        end

        // Drive the full value and start waiting, or end after the final step.
        if (do_strobe) begin
            n_lines = step_value(str_step, n_tx_hold);
            if (str_step == STEP_RFINAL) begin
                fin    = 1'b1;
                fin_rx = 1'b1;
            end else begin
                n_step     = str_step;
                n_wait     = 1'b1;
                n_poll_cnt = '0;
            end
        end

        if (fin) begin
            n_step = STEP_IDLE;
            n_wait = 1'b0;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poll_limit   <= POLL_LIMIT_RST;
            r_settle_ticks <= SETTLE_TICKS_RST;
            r_recv_retries <= RECV_RETRIES_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_POLL_LIMIT:   r_poll_limit   <= i_cfg_data[15:0];
                CFG_SETTLE_TICKS: r_settle_ticks <= i_cfg_data[7:0];
                CFG_RECV_RETRIES: r_recv_retries <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer state advances on each accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= STEP_IDLE;
            r_wait       <= 1'b0;
            r_poll_cnt   <= '0;
            r_settle_cnt <= 8'd0;
            r_retry      <= 5'd0;
            r_shift      <= 8'd0;
            r_bit_cnt    <= 4'd0;
            r_tx_hold    <= 8'd0;
            r_lines      <= 4'd0;
        end else if (in_accept) begin
            r_step       <= n_step;
            r_wait       <= n_wait;
            r_poll_cnt   <= n_poll_cnt;
            r_settle_cnt <= n_settle_cnt;
            r_retry      <= n_retry;
            r_shift      <= n_shift;
            r_bit_cnt    <= n_bit_cnt;
            r_tx_hold    <= n_tx_hold;
            r_lines      <= n_lines;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_lines <= n_lines;
            r_out_busy  <= (n_step != STEP_IDLE);
            r_out_done  <= fin;
            r_out_rx    <= (fin && fin_rx) ? n_shift : 8'd0;
            r_out_err   <= fin && fin_err;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_line_out = r_out_lines;
    assign o_busy_res = r_out_busy;
    assign o_done_res = r_out_done;
    assign o_rx_byte  = r_out_rx;
    assign o_error    = r_out_err;

    // A finished beat never reports the transfer as still running.
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_done_res |-> !o_busy_res)
        else $error("done beat reports busy");

    // An error or a received byte only appears on a finished beat.
    a_err_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_error || o_rx_byte != 8'd0) |-> o_done_res)
        else $error("error or data outside a done beat");

    // The idle step never carries a pending wait.
    a_idle_no_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step == STEP_IDLE |-> !r_wait)
        else $error("idle step with wait flag set");

    // The receive bit counter never runs past one byte.
    a_bit_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_cnt <= 4'd8)
        else $error("bit counter beyond eight");

    // The sequencer only moves on an accepted beat.
    a_state_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_accept |=> $stable(r_step) && $stable(r_lines))
        else $error("sequencer moved without an accepted beat");

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the parallel link byte transfer block. A predictor
// of the link sequencer computes the result of every accepted input beat.
// Partner status lines come from a responder that answers the awaited
// handshake most of the time, so sends and receives run to the end, and
// otherwise gives wrong status to reach the timeouts and request retries.
// Both channels idle and stall at random, and the registers are moved
// through several settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_top;
    import plbt_pkg::*;

    // Codes that the package does not name.
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam logic [1:0] STAT_ONE   = 2'd1;

    // Run limit in ns, far above the slowest correct run.
    localparam longint RUN_LIMIT_NS = 64'd10_000_000;

    // Expected result of one beat.
    typedef struct packed {
        logic [3:0] lines;
        logic       busy;
        logic       done;
        logic [7:0] rx;
        logic       err;
    } t_link_out;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid    = 1'b0;
    logic                  o_stall;
    logic [1:0]            i_mode     = '0;
    logic [7:0]            i_tx_byte  = '0;
    logic [1:0]            i_line_in  = '0;
    logic                  o_valid;
    logic                  i_stall    = 1'b0;
    logic [3:0]            o_line_out;
    logic                  o_busy_res;
    logic                  o_done_res;
    logic [7:0]            o_rx_byte;
    logic                  o_error;

    parallel_link_byte_transfer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_mode     (i_mode),
        .i_tx_byte  (i_tx_byte),
        .i_line_in  (i_line_in),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_line_out (o_line_out),
        .o_busy_res (o_busy_res),
        .o_done_res (o_done_res),
        .o_rx_byte  (o_rx_byte),
        .o_error    (o_error)
    );

    // Clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Register copies held by the predictor.
    logic [15:0] cfg_poll_limit   = POLL_LIMIT_RST;
    logic [7:0]  cfg_settle_ticks = SETTLE_TICKS_RST;
    logic [4:0]  cfg_recv_retries = RECV_RETRIES_RST;

    // Sequencer state held by the predictor.
    t_step       seq_step    = STEP_IDLE;
    logic        seq_waiting = 1'b0;
    logic [15:0] poll_cnt    = '0;
    logic [7:0]  settle_cnt  = '0;
    logic [4:0]  retry_cnt   = '0;
    logic [7:0]  rx_shift    = '0;
    logic [3:0]  rx_bits     = '0;
    logic [7:0]  tx_hold     = '0;
    logic [3:0]  lines_q     = '0;
    logic        fin_now, fin_err, fin_rx;

    t_link_out   link_results_due[$];

    // Bench bookkeeping.
    logic [7:0]  rx_target   = '0;
    bit          gaps_on     = 1'b1;
    int          burst_left  = 0;
    int          beats_sent  = 0;
    int          results_checked = 0;
    int          transfers_ended = 0;
    int          timeouts_seen   = 0;
    int          sends_started   = 0;
    int          recvs_started   = 0;
    int          cfg_sets        = 0;
    int          err_count       = 0;

    // Full line pattern that a step drives once its strobe is out.
    function automatic logic [3:0] lines_for_step(t_step s);
        case (s)
            STEP_SREQ:   return LINES_SEND_REQ;
            STEP_SG0:    return {1'b0, tx_hold[2:0]};
            STEP_SG1:    return {1'b1, tx_hold[5:3]};
            STEP_SG2:    return {2'b00, tx_hold[7:6]};
            STEP_RREQ1:  return LINES_RECV_REQ1;
            STEP_RREQ2:  return LINES_RECV_REQ2;
            STEP_RBIT:   return LINES_BIT_REQ;
            STEP_RZERO:  return LINES_ZERO_ACK;
            STEP_RONEA:  return LINES_ONE_ACKA;
            STEP_RONEB:  return LINES_ONE_ACKB;
            STEP_RONEC:  return LINES_STROBE;
            STEP_RFINAL: return LINES_BIT_REQ;
            default:     return 4'h0;
        endcase
    endfunction

    // Partner status that ends the wait of a step.
    function automatic logic [1:0] status_awaited(t_step s);
        case (s)
            STEP_SREQ, STEP_SG1, STEP_RREQ1, STEP_RONEA: return STAT_TWO;
            STEP_RONEB:                                  return STAT_ZERO;
            default:                                     return STAT_IDLE;
        endcase
    endfunction

    function automatic void link_finish(logic err, logic rx);
        fin_now     = 1'b1;
        fin_err     = err;
        fin_rx      = rx;
        seq_step    = STEP_IDLE;
        seq_waiting = 1'b0;
    endfunction

    // The strobe line takes its new value and the wait begins, or the final step ends the transfer.
    function automatic void link_strobe(t_step s);
        lines_q = lines_for_step(s);
        if (s == STEP_RFINAL) begin
            link_finish(1'b0, 1'b1);
        end else begin
            seq_step    = s;
            seq_waiting = 1'b1;
            poll_cnt    = '0;
        end
    endfunction

    // Low lines change first, with the old strobe kept.
    function automatic void link_enter(t_step s);
        logic [3:0] full;
        full       = lines_for_step(s);
        lines_q    = {lines_q[3], full[2:0]};
        settle_cnt = cfg_settle_ticks;
        if (settle_cnt == 0) begin
            link_strobe(s);
        end else begin
            seq_step    = s;
            seq_waiting = 1'b0;
        end
    endfunction

    // Advance the predicted sequencer by one beat and queue its result.
    function automatic void predict_link_tick(logic [1:0] mode, logic [7:0] txb,
                                              logic [1:0] st);
        t_link_out   r;
        logic [15:0] lim;
        logic        hit;
        lim     = (cfg_poll_limit == 0) ? 16'd1 : cfg_poll_limit;
        fin_now = 1'b0;
        fin_err = 1'b0;
        fin_rx  = 1'b0;
        if (seq_step == STEP_IDLE) begin
            // Only an idle sequencer takes a new transfer.
            if (mode == MODE_SEND) begin
                tx_hold = txb;
                link_enter(STEP_SREQ);
            end else if (mode == MODE_RECV) begin
                retry_cnt = '0;
                rx_bits   = '0;
                rx_shift  = '0;
                link_enter(STEP_RREQ1);
            end
        end else if (!seq_waiting) begin
            if (settle_cnt != 0) settle_cnt--;
            if (settle_cnt == 0) link_strobe(seq_step);
        end else begin
            hit = (seq_step == STEP_RBIT) ? (st != STAT_IDLE)
                                          : (st == status_awaited(seq_step));
            if (hit) begin
                case (seq_step)
                    STEP_SREQ:  link_enter(STEP_SG0);
                    STEP_SG0:   link_enter(STEP_SG1);
                    STEP_SG1:   link_enter(STEP_SG2);
                    STEP_SG2:   link_finish(1'b0, 1'b0);
                    STEP_RREQ1: link_enter(STEP_RREQ2);
                    STEP_RREQ2: link_enter(STEP_RBIT);
                    STEP_RBIT: begin
                        // Status two is a zero bit; bits arrive LSB first.
                        rx_shift = {st != STAT_TWO, rx_shift[7:1]};
                        rx_bits++;
                        link_enter(st != STAT_TWO ? STEP_RONEA : STEP_RZERO);
                    end
                    STEP_RONEA: link_enter(STEP_RONEB);
                    STEP_RONEB: link_enter(STEP_RONEC);
                    STEP_RZERO, STEP_RONEC:
                        link_enter(rx_bits >= 8 ? STEP_RFINAL : STEP_RBIT);
                    default: begin
                        seq_step    = STEP_IDLE;
                        seq_waiting = 1'b0;
                    end
                endcase
            end else begin
                if (poll_cnt != 16'hFFFF) poll_cnt++;
                if (poll_cnt >= lim) begin
                    // Request stages retry; every other wait fails at once.
                    if (seq_step inside {STEP_RREQ1, STEP_RREQ2}) begin
                        retry_cnt++;
                        if (retry_cnt >= cfg_recv_retries || retry_cnt == 0)
                            link_finish(1'b1, 1'b0);
                        else
                            link_enter(STEP_RREQ1);
                    end else begin
                        link_finish(1'b1, 1'b0);
                    end
                end
            end
        end
        r.lines = lines_q;
        r.busy  = (seq_step != STEP_IDLE);
        r.done  = fin_now;
        r.rx    = (fin_now && fin_rx) ? rx_shift : 8'h00;
        r.err   = fin_now && fin_err;
        link_results_due.push_back(r);
    endfunction

    // Partner model: answers the awaited status with the given odds.
    function automatic logic [1:0] partner_status(int good_pct);
        logic [1:0] s;
        if (seq_step == STEP_IDLE || !seq_waiting) return 2'($urandom_range(3));
        if ($urandom_range(99) < good_pct) begin
            if (seq_step == STEP_RBIT)
                return rx_target[rx_bits[2:0]] ?
                       ($urandom_range(1) ? STAT_ZERO : STAT_ONE) : STAT_TWO;
            return status_awaited(seq_step);
        end
        if (seq_step == STEP_RBIT) return STAT_IDLE;
        do s = 2'($urandom_range(3)); while (s == status_awaited(seq_step));
        return s;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        err_count++;
        if (err_count <= 40)
            $display("MISMATCH %s: got %0h, want %0h (result %0d)",
                     what, got, want, results_checked);
    endtask

    // Send one beat; with gaps on, the sender works in bursts with random gaps.
    task automatic send_beat(logic [1:0] mode, logic [7:0] txb, int good_pct);
        int gap;
        if (gaps_on) begin
            if (burst_left == 0) begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 16);
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left--;
        end
        i_valid   <= 1'b1;
        i_mode    <= mode;
        i_tx_byte <= txb;
        i_line_in <= partner_status(good_pct);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_link_tick(i_mode, i_tx_byte, i_line_in);
        beats_sent++;
    endtask

    // Wait until every result is in and the block is quiet.
    task automatic quiesce();
        int guard;
        i_valid <= 1'b0;
        guard = 0;
        while (link_results_due.size() != 0 && guard < 2000) begin
            @(posedge i_clk);
            guard++;
        end
        if (link_results_due.size() != 0) begin
            report_mismatch("results never returned", 16'(link_results_due.size()),
                            16'd0);
            link_results_due.delete();
        end
        repeat (3) @(posedge i_clk);
    endtask

    // Write all three registers on consecutive edges while idle.
    task automatic write_regs(logic [15:0] pl, logic [7:0] st, logic [4:0] rr);
        quiesce();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_POLL_LIMIT;
        i_cfg_data <= pl;
        @(posedge i_clk);
        cfg_poll_limit = pl;
        i_cfg_idx  <= CFG_SETTLE_TICKS;
        i_cfg_data <= {8'h00, st};
        @(posedge i_clk);
        cfg_settle_ticks = st;
        i_cfg_idx  <= CFG_RECV_RETRIES;
        i_cfg_data <= {11'h000, rr};
        @(posedge i_clk);
        cfg_recv_retries = rr;
        i_cfg_we <= 1'b0;
        cfg_sets++;
    endtask

    // Start one transfer and feed beats until it ends; modes sent while busy
    // must be ignored.
    task automatic run_transfer(logic [1:0] mode, logic [7:0] val, int good_pct);
        rx_target = val;
        if (mode == MODE_SEND) sends_started++;
        else                   recvs_started++;
        send_beat(mode, val, good_pct);
        while (seq_step != STEP_IDLE)
            send_beat(2'($urandom_range(3)), 8'($urandom_range(255)), good_pct);
    endtask

    // Plain and unused modes while idle, at reset values.
    task automatic test_idle_ticks();
        repeat (4) send_beat(MODE_TICK, 8'($urandom_range(255)), 100);
        repeat (4) send_beat(MODE_SPARE, 8'($urandom_range(255)), 100);
    endtask

    // Byte sends at the field extremes, with reset and with zero settle time.
    task automatic test_send_bytes();
        run_transfer(MODE_SEND, 8'hA5, 100);
        write_regs(16'd1000, 8'd0, 5'd20);
        run_transfer(MODE_SEND, 8'h00, 100);
        run_transfer(MODE_SEND, 8'hFF, 100);
        run_transfer(MODE_SEND, 8'($urandom_range(255)), 70);
    endtask

    // Byte receives of all zeros, all ones and a mixed pattern.
    task automatic test_receive_bytes();
        write_regs(16'd1000, 8'd0, 5'd20);
        run_transfer(MODE_RECV, 8'h00, 100);
        run_transfer(MODE_RECV, 8'hFF, 100);
        write_regs(16'd1000, 8'd2, 5'd20);
        run_transfer(MODE_RECV, 8'h5A, 80);
    endtask

    // Timeouts: zero poll limit, request retries including zero and one
    // allowed attempts, and timeouts spread over every wait.
    task automatic test_timeouts();
        write_regs(16'd0, 8'd1, 5'd3);
        run_transfer(MODE_SEND, 8'($urandom_range(255)), 0);
        run_transfer(MODE_RECV, 8'($urandom_range(255)), 0);
        write_regs(16'd2, 8'd0, 5'd0);
        run_transfer(MODE_RECV, 8'($urandom_range(255)), 0);
        write_regs(16'd1, 8'd0, 5'd1);
        run_transfer(MODE_RECV, 8'($urandom_range(255)), 0);
        write_regs(16'd1, 8'd0, 5'd2);
        repeat (3) begin
            run_transfer(MODE_RECV, 8'($urandom_range(255)), 85);
            run_transfer(MODE_SEND, 8'($urandom_range(255)), 60);
        end
    endtask

    // Largest settle time, largest poll limit, then the most request retries.
    task automatic test_slow_extremes();
        write_regs(16'd1, 8'd255, 5'd31);
        run_transfer(MODE_SEND, 8'($urandom_range(255)), 0);
        write_regs(16'd65535, 8'd0, 5'd31);
        run_transfer(MODE_SEND, 8'($urandom_range(255)), 100);
        write_regs(16'd1, 8'd0, 5'd31);
        run_transfer(MODE_RECV, 8'($urandom_range(255)), 0);
    endtask

    // Random transfers under changing settings.
    task automatic test_random_traffic();
        int stop_at;
        int good;
        for (int seg = 0; seg < 6; seg++) begin
            write_regs($urandom_range(3) == 0 ? 16'd1000 : 16'($urandom_range(1, 12)),
                       8'($urandom_range(0, 3)), 5'($urandom_range(1, 31)));
            gaps_on = (seg % 3 != 1);
            stop_at = beats_sent + 15;
            while (beats_sent < stop_at) begin
                good = $urandom_range(70, 100);
                if ($urandom_range(9) == 0)
                    send_beat($urandom_range(1) ? MODE_TICK : MODE_SPARE,
                              8'($urandom_range(255)), good);
                else
                    run_transfer($urandom_range(1) ? MODE_SEND : MODE_RECV,
                                 8'($urandom_range(255)), good);
            end
        end
        gaps_on = 1'b1;
    endtask

    // Receiver stall pattern: quiet, sparse, periodic and heavy stretches.
    logic [8:0] stall_cyc = '0;
    always @(posedge i_clk) begin
        stall_cyc <= stall_cyc + 9'd1;
        case (stall_cyc[8:7])
            2'd0:    i_stall <= 1'b0;
            2'd1:    i_stall <= ($urandom_range(3) == 0);
            2'd2:    i_stall <= (stall_cyc[1:0] == 2'b11);
            default: i_stall <= ($urandom_range(9) < 6);
        endcase
    end

    // Compare each accepted result beat with the oldest expectation.
    always @(posedge i_clk) begin : check_results
        t_link_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (link_results_due.size() == 0) begin
                report_mismatch("result with nothing due", {12'h000, o_line_out}, 16'd0);
            end else begin
                want = link_results_due.pop_front();
                if (o_line_out !== want.lines)
                    report_mismatch("line_out", 16'(o_line_out), 16'(want.lines));
                if (o_busy_res !== want.busy)
                    report_mismatch("busy_res", 16'(o_busy_res), 16'(want.busy));
                if (o_done_res !== want.done)
                    report_mismatch("done_res", 16'(o_done_res), 16'(want.done));
                if (o_rx_byte !== want.rx)
                    report_mismatch("rx_byte", 16'(o_rx_byte), 16'(want.rx));
                if (o_error !== want.err)
                    report_mismatch("error", 16'(o_error), 16'(want.err));
                results_checked++;
                if (want.done) begin
                    transfers_ended++;
                    if (want.err) timeouts_seen++;
                end
            end
        end
    end

    // Main sequence.
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_idle_ticks();
        test_send_bytes();
        test_receive_bytes();
        test_timeouts();
        test_slow_extremes();
        test_random_traffic();
        quiesce();
        $display("Run covered %0d beats and %0d results under %0d register settings.",
                 beats_sent, results_checked, cfg_sets);
        $display("Transfers: %0d sends, %0d receives, %0d ended, %0d by timeout.",
                 sends_started, recvs_started, transfers_ended, timeouts_seen);
        if (err_count == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // Hard stop for a hung run.
    initial begin
        #(RUN_LIMIT_NS);
        $display("Run limit reached with %0d results still due.",
                 link_results_due.size());
        $display("tb_top: errors");
        $finish;
    end

endmodule
